// ----- rtl/core/rgbhsv_pkg.sv -----
package rgbhsv_pkg;

	localparam int unsigned CHAIN_LEN = 8;

	localparam logic [10:0] HUE_WRAP  = 11'd1529;
	localparam logic [10:0] HUE_GREEN = 11'd510;
	localparam logic [10:0] HUE_BLUE  = 11'd1020;
	localparam logic [10:0] HUE_ZERO  = 11'd0;

	// One restoring divider lane. The dividend's high byte starts in rem and
	// its low byte is shifted in one bit per cell.
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] num_lo;
		logic [7:0] quo;
		logic [7:0] dvs;
	} div_lane_t;

	typedef struct packed {
		logic [10:0] base;
		logic        neg;
		logic        zero;
		logic [7:0]  brightness;
	} side_t;

	typedef struct packed {
		div_lane_t hue_div;
		div_lane_t sat_div;
		side_t     side;
	} beat_t;

	function automatic div_lane_t div_step(div_lane_t lane);
		logic [8:0] trial;
		div_lane_t  nxt;
		trial = {lane.rem, lane.num_lo[7]};
		nxt = lane;
		nxt.num_lo = {lane.num_lo[6:0], 1'b0};
		if (trial >= {1'b0, lane.dvs}) begin
			nxt.rem = 8'(trial - {1'b0, lane.dvs});
			nxt.quo = {lane.quo[6:0], 1'b1};
		end else begin
			nxt.rem = trial[7:0];
			nxt.quo = {lane.quo[6:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ----- rtl/core/rgb_to_hsv_converter.sv -----
// Channel  Handshake                  Payload
// pixel    pixel_valid / pixel_ready  red, green, blue (8 bits each)
// hsv      hsv_valid / hsv_ready      hue (11), saturation (8), brightness (8)
//
// One pixel per clock sustained while hsv_ready stays high.
// The pipeline is a front stage, eight restoring divide cells (one quotient bit each),
// and the output register.
// Asynchronous active-low reset empties every stage; no data is cleared.
// A stall at hsv_ready holds each occupied stage, and empty stages keep filling.
module rgb_to_hsv_converter import rgbhsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        hsv_valid,
	input  logic        hsv_ready,
	output logic [10:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness
);

	logic  chain_valid [CHAIN_LEN+1];
	logic  chain_ready [CHAIN_LEN+1];
	beat_t chain_beat  [CHAIN_LEN+1];

	rgbhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (pixel_valid),
		.ready_o (pixel_ready),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.valid_o (chain_valid[0]),
		.ready_i (chain_ready[0]),
		.beat_o  (chain_beat[0])
	);

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		rgbhsv_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (chain_valid[i]),
			.ready_o (chain_ready[i]),
			.beat_i  (chain_beat[i]),
			.valid_o (chain_valid[i+1]),
			.ready_i (chain_ready[i+1]),
			.beat_o  (chain_beat[i+1])
		);
	end

	rgbhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_i    (chain_valid[CHAIN_LEN]),
		.ready_o    (chain_ready[CHAIN_LEN]),
		.beat_i     (chain_beat[CHAIN_LEN]),
		.valid_o    (hsv_valid),
		.ready_i    (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule

// ----- rtl/core/rgbhsv_front.sv -----
module rgbhsv_front import rgbhsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_i,
	output logic       ready_o,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       valid_o,
	input  logic       ready_i,
	output beat_t      beat_o
);

	logic        valid_s1;
	beat_t       beat_s1;
	logic [7:0]  mx, mn, dlt, hi, lo, mag;
	logic        neg;
	logic [10:0] base;
	logic [15:0] num_h, num_s;
	beat_t       beat_d;

	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		dlt = mx - mn;
		if (red == mx) begin
			hi = green;
			lo = blue;
		end else if (green == mx) begin
			hi = blue;
			lo = red;
		end else begin
			hi = red;
			lo = green;
		end
		neg = hi < lo;
		mag = neg ? (lo - hi) : (hi - lo);
		// Red wraps below zero onto the top of the hue circle.
		if (red == mx) begin
			base = neg ? HUE_WRAP : HUE_ZERO;
		end else if (green == mx) begin
			base = HUE_GREEN;
		end else begin
			base = HUE_BLUE;
		end
		num_h = {mag, 8'd0} - {8'd0, mag};
		num_s = {dlt, 8'd0} - {8'd0, dlt};
		beat_d.hue_div.rem    = num_h[15:8];
		beat_d.hue_div.num_lo = num_h[7:0];
		beat_d.hue_div.quo    = 8'd0;
		beat_d.hue_div.dvs    = dlt;
		beat_d.sat_div.rem    = num_s[15:8];
		beat_d.sat_div.num_lo = num_s[7:0];
		beat_d.sat_div.quo    = 8'd0;
		beat_d.sat_div.dvs    = mx;
		beat_d.side.base       = base;
		beat_d.side.neg        = neg;
		beat_d.side.zero       = (dlt == 8'd0);
		beat_d.side.brightness = mx;
	end

	assign ready_o = !valid_s1 || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_o) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			beat_s1 <= beat_d;
		end
	end

	assign valid_o = valid_s1;
	assign beat_o  = beat_s1;

endmodule

// ----- rtl/core/rgbhsv_div_cell.sv -----
module rgbhsv_div_cell import rgbhsv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_i,
	output logic  ready_o,
	input  beat_t beat_i,
	output logic  valid_o,
	input  logic  ready_i,
	output beat_t beat_o
);

	logic  valid_q;
	beat_t beat_q;

	assign ready_o = !valid_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			beat_q.hue_div <= div_step(beat_i.hue_div);
			beat_q.sat_div <= div_step(beat_i.sat_div);
			beat_q.side    <= beat_i.side;
		end
	end

	assign valid_o = valid_q;
	assign beat_o  = beat_q;

`ifndef ASSERT_OFF
	// The partial remainder stays below the divisor for every real division.
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !beat_q.side.zero |-> beat_q.hue_div.rem < beat_q.hue_div.dvs)
		else $error("hue remainder not below divisor");
	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !beat_q.side.zero |-> beat_q.sat_div.rem < beat_q.sat_div.dvs)
		else $error("saturation remainder not below divisor");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready_i |=> valid_q && $stable(beat_q))
		else $error("stalled cell lost its beat");
`endif

endmodule

// ----- rtl/core/rgbhsv_back.sv -----
module rgbhsv_back import rgbhsv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_i,
	output logic        ready_o,
	input  beat_t       beat_i,
	output logic        valid_o,
	input  logic        ready_i,
	output logic [10:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness
);

	logic        valid_q;
	logic [10:0] hue_q;
	logic [7:0]  sat_q, bright_q;
	logic [8:0]  quo_up;
	logic [10:0] hue_d;
	logic [7:0]  sat_d;

	always_comb begin
		// A negative offset rounds toward minus infinity, so the quotient rounds up.
		quo_up = {1'b0, beat_i.hue_div.quo} + {8'd0, (beat_i.hue_div.rem != 8'd0)};
		if (beat_i.side.zero) begin
			hue_d = HUE_ZERO;
			sat_d = 8'd0;
		end else begin
			hue_d = beat_i.side.neg ? (beat_i.side.base - {2'b0, quo_up})
			                        : (beat_i.side.base + {3'b0, beat_i.hue_div.quo});
			sat_d = beat_i.sat_div.quo;
		end
	end

	assign ready_o = !valid_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			hue_q    <= hue_d;
			sat_q    <= sat_d;
			bright_q <= beat_i.side.brightness;
		end
	end

	assign valid_o    = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

`ifndef ASSERT_OFF
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> hue_q < HUE_WRAP)
		else $error("hue out of range");
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && bright_q == 8'd0 |-> hue_q == HUE_ZERO && sat_q == 8'd0)
		else $error("black pixel with nonzero hue or saturation");
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		valid_i && ready_o && beat_i.side.zero |=> hue_q == HUE_ZERO && sat_q == 8'd0)
		else $error("gray pixel with nonzero hue or saturation");
`endif

endmodule

// ----- verif/rgb_to_hsv_converter_tb.sv -----
module rgb_to_hsv_converter_tb;

	localparam int HUE_RED_BASE   = 1529;
	localparam int HUE_GREEN_BASE = 510;
	localparam int HUE_BLUE_BASE  = 1020;
	localparam int HUE_SPAN       = 1529;
	localparam int STEP           = 255;
	localparam int RANDOM_PIXELS  = 1100;
	localparam int CALM_TAIL      = 150;
	localparam int DRAIN_CYCLES   = 30;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [10:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pixel_valid = 1'b0;
	logic        pixel_ready;
	logic [7:0]  red = 8'd0;
	logic [7:0]  green = 8'd0;
	logic [7:0]  blue = 8'd0;
	logic        hsv_valid;
	logic        hsv_ready = 1'b0;
	logic [10:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;

	pixel_t pixel_q[$];
	hsv_t   hsv_expect[$];
	pixel_t next_pixel;
	hsv_t   want;
	int     pixels_sent = 0;
	int     results_seen = 0;
	int     send_gap = 0;
	int     stall_left = 0;
	int     error_count = 0;

	rgb_to_hsv_converter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.hsv_valid   (hsv_valid),
		.hsv_ready   (hsv_ready),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness)
	);

	always #1 clk = ~clk;

	// Hue, saturation and value of one pixel, using exact integer floor division.
	function automatic hsv_t hsv_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int   mx;
		int   mn;
		int   d;
		int   hi;
		int   lo;
		int   base;
		int   h;
		int   s;
		hsv_t res;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d = mx - mn;
		h = 0;
		s = 0;
		if (mx != 0 && d != 0) begin
			if (r == mx) begin
				base = HUE_RED_BASE;
				hi = g;
				lo = b;
			end else if (g == mx) begin
				base = HUE_GREEN_BASE;
				hi = b;
				lo = r;
			end else begin
				base = HUE_BLUE_BASE;
				hi = r;
				lo = g;
			end
			// A negative offset rounds toward minus infinity, so its magnitude rounds up.
			if (hi >= lo)
				h = base + (STEP * (hi - lo)) / d;
			else
				h = base - (STEP * (lo - hi) + d - 1) / d;
			if (r == mx && h >= HUE_SPAN)
				h = h - HUE_SPAN;
			s = (d * STEP) / mx;
		end
		res.hue = 11'(h);
		res.saturation = 8'(s);
		res.brightness = 8'(mx);
		return res;
	endfunction

	task automatic add_pixel(int r, int g, int b);
		pixel_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		pixel_q.push_back(p);
	endtask

	// Idle bursts only happen in alternating windows of beats and never near the end.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pixel_valid && pixel_ready) begin
				hsv_expect.push_back(hsv_of(red, green, blue));
				pixels_sent++;
			end
			if (!pixel_valid || pixel_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pixel_valid <= 1'b0;
				end else if (pixel_q.size() > CALM_TAIL && pixels_sent[6]
						&& $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 14);
					pixel_valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					next_pixel = pixel_q.pop_front();
					pixel_valid <= 1'b1;
					red <= next_pixel.red;
					green <= next_pixel.green;
					blue <= next_pixel.blue;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hsv_valid && hsv_ready) begin
				results_seen++;
				if (hsv_expect.size() == 0) begin
					$error("hsv beat with no pixel pending: hue %0d saturation %0d brightness %0d",
						hue, saturation, brightness);
					error_count++;
				end else begin
					want = hsv_expect.pop_front();
					if (hue !== want.hue) begin
						$error("hue: expected %0d, actual %0d", want.hue, hue);
						error_count++;
					end
					if (saturation !== want.saturation) begin
						$error("saturation: expected %0d, actual %0d", want.saturation, saturation);
						error_count++;
					end
					if (brightness !== want.brightness) begin
						$error("brightness: expected %0d, actual %0d", want.brightness, brightness);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				hsv_ready <= 1'b0;
			end else if (pixel_q.size() > CALM_TAIL && results_seen[5]
					&& $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 14);
				hsv_ready <= 1'b0;
			end else begin
				hsv_ready <= 1'b1;
			end
		end
	end

	initial begin
		int kind;
		int lvl;
		int r;
		int g;
		int b;

		// Black, white, grays, primaries, and ties between the largest channels.
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(128, 128, 128);
		add_pixel(1, 1, 1);
		add_pixel(255, 0, 0);
		add_pixel(0, 255, 0);
		add_pixel(0, 0, 255);
		add_pixel(255, 255, 0);
		add_pixel(0, 255, 255);
		add_pixel(255, 0, 255);
		add_pixel(255, 0, 1);
		add_pixel(255, 1, 0);
		add_pixel(1, 0, 0);
		add_pixel(0, 0, 1);
		add_pixel(0, 1, 0);
		add_pixel(255, 254, 255);
		add_pixel(2, 1, 0);
		add_pixel(0, 1, 2);
		add_pixel(255, 0, 128);
		add_pixel(128, 0, 255);
		add_pixel(0, 255, 128);
		add_pixel(1, 0, 1);
		add_pixel(254, 255, 0);
		add_pixel(170, 85, 0);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			kind = $urandom_range(0, 9);
			r = $urandom_range(0, 255);
			g = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
			case (kind)
				5: begin
					g = r;
					b = r;
				end
				6: begin
					lvl = $urandom_range(0, 2);
					if (lvl == 0)
						g = r;
					else if (lvl == 1)
						b = g;
					else
						r = b;
				end
				7: begin
					// Small spread between channels stresses the divider remainders.
					lvl = $urandom_range(3, 252);
					r = lvl + $urandom_range(0, 6) - 3;
					g = lvl + $urandom_range(0, 6) - 3;
					b = lvl + $urandom_range(0, 6) - 3;
				end
				8: begin
					r = $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
					g = $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
					b = $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1);
				end
				9: begin
					lvl = $urandom_range(0, 2);
					if (lvl == 0)
						r = 255;
					else if (lvl == 1)
						g = 255;
					else
						b = 255;
				end
				default: begin
				end
			endcase
			add_pixel(r, g, b);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_q.size() > 0 || pixel_valid)
			@(posedge clk);
		while (hsv_expect.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("rgb_to_hsv_converter_tb: PASS");
		else
			$display("rgb_to_hsv_converter_tb: FAIL");
		$finish;
	end

	initial begin
		#1000000;
		$display("rgb_to_hsv_converter_tb: FAIL");
		$finish;
	end

endmodule
